// ===== rtl/ess_pkg.sv =====
// shared types and constants for the error set statistics block
`timescale 1ns / 1ps

package ess_pkg;

    localparam int FIELD_W = 24;
    localparam int COUNT_W = 11;
    localparam int SUM_W   = 34;
    localparam int SQ_W    = 48;
    localparam int WIDE_W  = 58;
    localparam int ROOT_W  = 29;
    localparam int REM_W   = 32;

    typedef logic [FIELD_W-1:0] t_sample;

    // what one cell shows its neighbours
    typedef struct packed {
        logic    valid;
        logic    le;
        t_sample value;
    } t_link;

    // broadcast control for the whole chain
    typedef struct packed {
        logic    ins;
        logic    shift;
        t_sample x;
    } t_cell_ctl;

endpackage

// ===== rtl/ess_in_if.sv =====
// input channel: at most one deviation sample per transaction
`timescale 1ns / 1ps

interface ess_in_if;
    logic                         valid;
    logic                         ready;
    logic [ess_pkg::FIELD_W-1:0]  distance;
    logic                         carries_value;
    logic                         last_sample;

    modport source (output valid, output distance, output carries_value,
                    output last_sample, input ready);
    modport sink   (input valid, input distance, input carries_value,
                    input last_sample, output ready);
endinterface

// ===== rtl/ess_out_if.sv =====
// output channel: one statistics result per transaction
`timescale 1ns / 1ps

interface ess_out_if;
    logic                         valid;
    logic                         ready;
    logic [ess_pkg::FIELD_W-1:0]  mean_value;
    logic [ess_pkg::FIELD_W-1:0]  rms_error;
    logic [ess_pkg::FIELD_W-1:0]  median_value;
    logic [ess_pkg::FIELD_W-1:0]  std_dev;
    logic [ess_pkg::FIELD_W-1:0]  minimum;
    logic [ess_pkg::FIELD_W-1:0]  maximum;
    logic [ess_pkg::COUNT_W-1:0]  sample_count;
    logic                         overflowed;

    modport source (output valid, output mean_value, output rms_error,
                    output median_value, output std_dev, output minimum,
                    output maximum, output sample_count, output overflowed,
                    input ready);
    modport sink   (input valid, input mean_value, input rms_error,
                    input median_value, input std_dev, input minimum,
                    input maximum, input sample_count, input overflowed,
                    output ready);
endinterface

// ===== rtl/ess_cell.sv =====
// one cell of the sorting chain: holds one sample, inserts in order, shifts out
`timescale 1ns / 1ps

module ess_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ess_pkg::t_cell_ctl i_ctl,
    input  ess_pkg::t_link     i_prev,
    input  ess_pkg::t_link     i_next,
    output ess_pkg::t_link     o_link
);
    import ess_pkg::*;

    logic    r_valid;
    t_sample r_value;
    logic    le_mine;

    // stored value stays in place when it is not above the new sample
    assign le_mine = r_valid && (r_value <= i_ctl.x);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.ins) begin
            if (!le_mine) begin
                if (i_prev.le) begin
                    r_value <= i_ctl.x;
                    r_valid <= 1'b1;
                end else begin
                    r_value <= i_prev.value;
                    r_valid <= i_prev.valid;
                end
            end
        end else if (i_ctl.shift) begin
            r_value <= i_next.value;
            r_valid <= i_next.valid;
        end
    end

    assign o_link.valid = r_valid;
    assign o_link.le    = le_mine;
    assign o_link.value = r_value;

endmodule

// ===== rtl/ess_div.sv =====
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module ess_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [ess_pkg::WIDE_W-1:0]  i_num,
    input  logic [ess_pkg::COUNT_W-1:0] i_den,
    output logic                        o_done,
    output logic [ess_pkg::WIDE_W-1:0]  o_quot
);
    import ess_pkg::*;

    localparam int CNT_W = $clog2(WIDE_W);

    logic               r_busy;
    logic               r_done;
    logic [CNT_W-1:0]   r_cnt;
    logic [WIDE_W-1:0]  r_q;
    logic [COUNT_W-1:0] r_rem;
    logic [COUNT_W-1:0] r_den;
    logic [COUNT_W:0]   trial;
    logic               fits;

    // shift in the next dividend bit and test against the divisor
    assign trial = {r_rem, r_q[WIDE_W-1]};
    assign fits  = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_q    <= i_num;
                r_rem  <= '0;
                r_den  <= i_den;
            end else if (r_busy) begin
                r_rem <= fits ? COUNT_W'(trial - {1'b0, r_den}) : COUNT_W'(trial);
                r_q   <= {r_q[WIDE_W-2:0], fits};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(WIDE_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

// ===== rtl/ess_sqrt.sv =====
// floor square root, one root bit per cycle
`timescale 1ns / 1ps

module ess_sqrt (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [ess_pkg::WIDE_W-1:0]  i_op,
    output logic                        o_done,
    output logic [ess_pkg::ROOT_W-1:0]  o_root
);
    import ess_pkg::*;

    localparam int CNT_W = $clog2(ROOT_W);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [WIDE_W-1:0] r_op;
    logic [REM_W-1:0]  r_rem;
    logic [ROOT_W-1:0] r_root;
    logic [REM_W-1:0]  rem_in;
    logic [REM_W-1:0]  trial;
    logic              fits;

    // bring down two operand bits, try root*4+1
    assign rem_in = {r_rem[REM_W-3:0], r_op[WIDE_W-1 -: 2]};
    assign trial  = {1'b0, r_root, 2'b01};
    assign fits   = rem_in >= trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_op   <= i_op;
                r_rem  <= '0;
                r_root <= '0;
            end else if (r_busy) begin
                r_rem  <= fits ? rem_in - trial : rem_in;
                r_root <= {r_root[ROOT_W-2:0], fits};
                r_op   <= {r_op[WIDE_W-3:0], 2'b00};
                r_cnt  <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(ROOT_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

// ===== rtl/error_set_statistics.sv =====
// error set statistics: mean, rmse, std dev, median, min, max of a sample set
// samples load at one per cycle into a sorted chain of cells while the set is open
// after the closing transaction the result is computed by
// three 58-step divisions, two 29-step roots and a shift of the chain through its head
// input is not taken until the result is registered; an empty set skips all of these
// synchronous active-low reset clears the chain valid bits, sums and control
`timescale 1ns / 1ps

module error_set_statistics #(
    parameter int SAMPLE_DEPTH = 1024,
    parameter int SAMPLE_BITS  = 24
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    ess_in_if.sink       i_samples,
    ess_out_if.source    o_stats
);
    import ess_pkg::*;

    localparam int CW = $clog2(SAMPLE_DEPTH + 1);
    localparam t_sample SampleMask = t_sample'((64'd1 << SAMPLE_BITS) - 64'd1);

    typedef enum logic [4:0] {
        S_LOAD, S_DR1, S_DR2, S_MEAN_GO, S_MEAN_W, S_MS_GO, S_MS_W,
        S_RMS_GO, S_RMS_W, S_VAR, S_VD1, S_VD2, S_VDIV_GO, S_VDIV_W,
        S_SD_GO, S_SD_W, S_PUT
    } t_state;

    t_state            r_state;
    logic [CW-1:0]     r_count;
    logic [CW-1:0]     r_idx;
    logic              r_drop;
    t_sample           r_min;
    t_sample           r_max;
    t_sample           r_p_x;
    logic [SQ_W-1:0]   r_sq;
    logic [SUM_W-1:0]  r_sum;
    logic [WIDE_W-1:0] r_sqsum;
    t_sample           r_diff;
    logic [SQ_W-1:0]   r_dsq;
    logic [WIDE_W-1:0] r_vacc;
    logic [WIDE_W-1:0] r_root_in;
    t_sample           r_mean;
    t_sample           r_rms;
    t_sample           r_sd;
    t_sample           r_lo;
    t_sample           r_hi;

    logic               r_out_valid;
    t_sample            r_o_mean;
    t_sample            r_o_rms;
    t_sample            r_o_median;
    t_sample            r_o_sd;
    t_sample            r_o_min;
    t_sample            r_o_max;
    logic [COUNT_W-1:0] r_o_count;
    logic               r_o_drop;

    logic              in_hs;
    logic              out_hs;
    logic              full;
    logic              store;
    t_sample           x;
    t_sample           head;
    t_sample           absdiff;
    logic [CW-1:0]     lo_idx;
    logic [CW-1:0]     hi_idx;
    logic              div_start;
    logic [WIDE_W-1:0] div_num;
    logic              div_done;
    logic [WIDE_W-1:0] div_quot;
    logic              sq_start;
    logic              sq_done;
    logic [ROOT_W-1:0] sq_root;
    logic              put_ok;
    t_cell_ctl         ctl;
    t_link             fwd [0:SAMPLE_DEPTH+1];

    // handshakes and sample selection
    assign in_hs  = i_samples.valid && i_samples.ready;
    assign out_hs = o_stats.valid && o_stats.ready;
    assign full   = (r_count == CW'(SAMPLE_DEPTH));
    assign x      = i_samples.distance & SampleMask;
    assign store  = i_samples.carries_value && !full;
    assign head   = fwd[1].value;
    assign lo_idx = (r_count - CW'(1)) >> 1;
    assign hi_idx = r_count >> 1;
    assign absdiff = (head >= r_mean) ? head - r_mean : r_mean - head;
    assign put_ok = !r_out_valid || out_hs;

    // shared unit control
    always_comb begin
        div_start = (r_state == S_MEAN_GO) || (r_state == S_MS_GO) ||
                    (r_state == S_VDIV_GO);
        sq_start  = (r_state == S_RMS_GO) || (r_state == S_SD_GO);
        case (r_state)
            S_MS_GO:   div_num = r_sqsum;
            S_VDIV_GO: div_num = r_vacc;
            default:   div_num = WIDE_W'(r_sum);
        endcase
    end

    // chain control
    assign ctl.ins   = in_hs && store;
    assign ctl.shift = (r_state == S_VAR);
    assign ctl.x     = x;

    // chain boundaries: a head that always accepts, a tail that is empty
    assign fwd[0]              = '{valid: 1'b1, le: 1'b1, value: '0};
    assign fwd[SAMPLE_DEPTH+1] = '0;

    for (genvar g = 0; g < SAMPLE_DEPTH; g++) begin : g_cell
        ess_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_ctl  (ctl),
            .i_prev (fwd[g]),
            .i_next (fwd[g+2]),
            .o_link (fwd[g+1])
        );
    end

    ess_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(div_start),
        .i_num  (div_num),
        .i_den  (COUNT_W'(r_count)),
        .o_done (div_done),
        .o_quot (div_quot)
    );

    ess_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(sq_start),
        .i_op   (r_root_in),
        .o_done (sq_done),
        .o_root (sq_root)
    );

    // accumulation pipelines run every cycle; idle stages carry zero
    always_ff @(posedge i_clk) begin
        r_sq  <= r_p_x * r_p_x;
        r_dsq <= r_diff * r_diff;
    end

    // sequencer, set statistics and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_count     <= '0;
            r_drop      <= 1'b0;
            r_min       <= '1;
            r_max       <= '0;
            r_p_x       <= '0;
            r_sum       <= '0;
            r_sqsum     <= '0;
            r_diff      <= '0;
            r_vacc      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_p_x   <= '0;
            r_diff  <= '0;
            r_sum   <= r_sum + SUM_W'(r_p_x);
            r_sqsum <= r_sqsum + WIDE_W'(r_sq);
            r_vacc  <= r_vacc + WIDE_W'(r_dsq);
            if (out_hs) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_LOAD: begin
                    if (in_hs) begin
                        if (store) begin
                            r_count <= r_count + 1'b1;
                            r_p_x   <= x;
                            if (x < r_min) r_min <= x;
                            if (x > r_max) r_max <= x;
                        end else if (i_samples.carries_value) begin
                            r_drop <= 1'b1;
                        end
                        if (i_samples.last_sample) r_state <= S_DR1;
                    end
                end
                S_DR1: r_state <= S_DR2;
                S_DR2: begin
                    if (r_count == '0) begin
                        r_mean  <= '0;
                        r_rms   <= '0;
                        r_sd    <= '0;
                        r_lo    <= '0;
                        r_hi    <= '0;
                        r_state <= S_PUT;
                    end else begin
                        r_state <= S_MEAN_GO;
                    end
                end
                S_MEAN_GO: r_state <= S_MEAN_W;
                S_MEAN_W: begin
                    if (div_done) begin
                        r_mean  <= FIELD_W'(div_quot);
                        r_state <= S_MS_GO;
                    end
                end
                S_MS_GO: r_state <= S_MS_W;
                S_MS_W: begin
                    if (div_done) begin
                        r_root_in <= div_quot;
                        r_state   <= S_RMS_GO;
                    end
                end
                S_RMS_GO: r_state <= S_RMS_W;
                S_RMS_W: begin
                    if (sq_done) begin
                        r_rms   <= FIELD_W'(sq_root);
                        r_idx   <= '0;
                        r_state <= S_VAR;
                    end
                end
                // sorted samples leave the head one per cycle
                S_VAR: begin
                    r_diff <= absdiff;
                    if (r_idx == lo_idx) r_lo <= head;
                    if (r_idx == hi_idx) r_hi <= head;
                    r_idx <= r_idx + 1'b1;
                    if (r_idx + CW'(1) == r_count) r_state <= S_VD1;
                end
                S_VD1: r_state <= S_VD2;
                S_VD2: r_state <= S_VDIV_GO;
                S_VDIV_GO: r_state <= S_VDIV_W;
                S_VDIV_W: begin
                    if (div_done) begin
                        r_root_in <= div_quot;
                        r_state   <= S_SD_GO;
                    end
                end
                S_SD_GO: r_state <= S_SD_W;
                S_SD_W: begin
                    if (sq_done) begin
                        r_sd    <= FIELD_W'(sq_root);
                        r_state <= S_PUT;
                    end
                end
                S_PUT: begin
                    if (put_ok) begin
                        r_out_valid <= 1'b1;
                        r_o_mean    <= r_mean;
                        r_o_rms     <= r_rms;
                        r_o_median  <= FIELD_W'(({1'b0, r_lo} + {1'b0, r_hi}) >> 1);
                        r_o_sd      <= r_sd;
                        r_o_min     <= (r_count == '0) ? '0 : r_min;
                        r_o_max     <= r_max;
                        r_o_count   <= COUNT_W'(r_count);
                        r_o_drop    <= r_drop;
                        r_count     <= '0;
                        r_drop      <= 1'b0;
                        r_min       <= '1;
                        r_max       <= '0;
                        r_sum       <= '0;
                        r_sqsum     <= '0;
                        r_vacc      <= '0;
                        r_state     <= S_LOAD;
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    assign i_samples.ready      = (r_state == S_LOAD);
    assign o_stats.valid        = r_out_valid;
    assign o_stats.mean_value   = r_o_mean;
    assign o_stats.rms_error    = r_o_rms;
    assign o_stats.median_value = r_o_median;
    assign o_stats.std_dev      = r_o_sd;
    assign o_stats.minimum      = r_o_min;
    assign o_stats.maximum      = r_o_max;
    assign o_stats.sample_count = r_o_count;
    assign o_stats.overflowed   = r_o_drop;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(SAMPLE_DEPTH))
        else $error("stored count above store depth");

    a_div_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_MEAN_W || r_state == S_MS_W || r_state == S_VDIV_W))
        else $error("divider finished outside a wait state");

    a_out_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_hs && r_state != S_PUT) |=> !r_out_valid)
        else $error("result repeated after transaction");

    a_median_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> (r_o_count == '0 ||
            (r_o_min <= r_o_median && r_o_median <= r_o_max)))
        else $error("median outside minimum and maximum");
`endif

endmodule

// ===== dv/tb.sv =====
// testbench for the error set statistics block: queued sample sets in, statistics checked
`timescale 1ns / 1ps

module tb;
    import ess_pkg::*;

    localparam int DEPTH     = 1024;
    localparam int WDOG_MAX  = 400000;
    localparam int HOLD_LEN  = 3000;

    typedef struct packed {
        logic [FIELD_W-1:0] distance;
        logic               carries_value;
        logic               last_sample;
    } t_item;

    typedef struct packed {
        logic [FIELD_W-1:0] mean_value;
        logic [FIELD_W-1:0] rms_error;
        logic [FIELD_W-1:0] median_value;
        logic [FIELD_W-1:0] std_dev;
        logic [FIELD_W-1:0] minimum;
        logic [FIELD_W-1:0] maximum;
        logic [COUNT_W-1:0] sample_count;
        logic               overflowed;
    } t_stats;

    logic i_clk;
    logic i_rst_n;

    ess_in_if  samples_if ();
    ess_out_if stats_if ();

    error_set_statistics i_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_samples (samples_if.sink),
        .o_stats   (stats_if.source)
    );

    // pending transactions and expected statistics
    t_item  pending_items[$];
    t_stats expected_stats[$];
    int     fail_count;
    bit     stim_done;
    bit     busy_wait;       // sender pauses until every result has come
    bit     calm_phase;      // no idling on either side
    int     hold_cycles;     // receiver hold-off counter
    int     idle_count;
    bit     in_acc;          // input transaction taken at the last rising edge

    // set state of the predictor
    logic [FIELD_W-1:0] set_samples[DEPTH];
    int unsigned        set_len;
    logic [SUM_W-1:0]   set_sum;
    logic [WIDE_W-1:0]  set_sq_sum;
    logic [FIELD_W-1:0] set_min;
    logic [FIELD_W-1:0] set_max;
    bit                 set_dropped;

    function automatic logic [63:0] floor_root(logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    task automatic clear_set();
        set_len     = 0;
        set_sum     = '0;
        set_sq_sum  = '0;
        set_min     = '1;
        set_max     = '0;
        set_dropped = 0;
    endtask

    // statistics predictor, called for each accepted transaction
    task automatic predict_stats(t_item it);
        t_stats             s;
        logic [63:0]        mean;
        logic [63:0]        var_sum;
        logic [63:0]        d;
        logic [FIELD_W-1:0] sorted[$];
        int unsigned        n;
        if (it.carries_value) begin
            if (set_len < DEPTH) begin
                set_samples[set_len] = it.distance;
                set_len++;
                set_sum    += SUM_W'(it.distance);
                set_sq_sum += WIDE_W'(64'(it.distance) * 64'(it.distance));
                if (it.distance < set_min) set_min = it.distance;
                if (it.distance > set_max) set_max = it.distance;
            end else begin
                set_dropped = 1;
            end
        end
        if (!it.last_sample) return;
        s = '0;
        s.overflowed = set_dropped;
        n = set_len;
        if (n != 0) begin
            mean = 64'(set_sum) / n;
            var_sum = 0;
            for (int k = 0; k < n; k++) begin
                d = (set_samples[k] >= mean) ? set_samples[k] - mean : mean - set_samples[k];
                var_sum += d * d;
                sorted.insert(sorted.size(), set_samples[k]);
            end
            sorted.sort();
            s.mean_value   = mean[FIELD_W-1:0];
            s.rms_error    = FIELD_W'(floor_root(64'(set_sq_sum) / n));
            s.std_dev      = FIELD_W'(floor_root(var_sum / n));
            s.median_value = (n % 2 == 0)
                ? FIELD_W'((25'(sorted[n/2-1]) + 25'(sorted[n/2])) >> 1) : sorted[n/2];
            s.minimum      = set_min;
            s.maximum      = set_max;
            s.sample_count = COUNT_W'(n);
        end
        expected_stats.insert(expected_stats.size(), s);
        clear_set();
    endtask

    // clock
    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // driver: offers pending transactions, changes at the falling edge
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            samples_if.valid <= 0;
        end else if (samples_if.valid && !in_acc) begin
            // hold the offer
        end else if (pending_items.size() != 0 && !busy_wait
                     && (calm_phase || $urandom_range(99) >= 37)) begin
            samples_if.valid         <= 1;
            samples_if.distance      <= pending_items[0].distance;
            samples_if.carries_value <= pending_items[0].carries_value;
            samples_if.last_sample   <= pending_items[0].last_sample;
            pending_items.pop_front();
        end else begin
            samples_if.valid <= 0;
        end
    end

    // receiver readiness, with one long hold-off
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles    <= hold_cycles - 1;
            stats_if.ready <= 0;
        end else begin
            stats_if.ready <= calm_phase || $urandom_range(99) >= 37;
        end
    end

    // monitor: predicts on accepted inputs and checks accepted results
    always @(posedge i_clk) begin
        t_stats got;
        t_stats want;
        bit     any_hs;
        in_acc <= samples_if.valid && samples_if.ready;
        if (i_rst_n) begin
            any_hs = 0;
            if (samples_if.valid && samples_if.ready) begin
                any_hs = 1;
                predict_stats({samples_if.distance, samples_if.carries_value,
                               samples_if.last_sample});
            end
            if (stats_if.valid && stats_if.ready) begin
                any_hs = 1;
                got = {stats_if.mean_value, stats_if.rms_error, stats_if.median_value,
                       stats_if.std_dev, stats_if.minimum, stats_if.maximum,
                       stats_if.sample_count, stats_if.overflowed};
                if (expected_stats.size() == 0) begin
                    $error("result with no expectation waiting");
                    fail_count++;
                end else begin
                    want = expected_stats.pop_front();
                    if (got.mean_value !== want.mean_value) begin
                        $error("mean_value exp %0d got %0d", want.mean_value, got.mean_value);
                        fail_count++;
                    end
                    if (got.rms_error !== want.rms_error) begin
                        $error("rms_error exp %0d got %0d", want.rms_error, got.rms_error);
                        fail_count++;
                    end
                    if (got.median_value !== want.median_value) begin
                        $error("median_value exp %0d got %0d", want.median_value,
                               got.median_value);
                        fail_count++;
                    end
                    if (got.std_dev !== want.std_dev) begin
                        $error("std_dev exp %0d got %0d", want.std_dev, got.std_dev);
                        fail_count++;
                    end
                    if (got.minimum !== want.minimum) begin
                        $error("minimum exp %0d got %0d", want.minimum, got.minimum);
                        fail_count++;
                    end
                    if (got.maximum !== want.maximum) begin
                        $error("maximum exp %0d got %0d", want.maximum, got.maximum);
                        fail_count++;
                    end
                    if (got.sample_count !== want.sample_count) begin
                        $error("sample_count exp %0d got %0d", want.sample_count,
                               got.sample_count);
                        fail_count++;
                    end
                    if (got.overflowed !== want.overflowed) begin
                        $error("overflowed exp %0d got %0d", want.overflowed, got.overflowed);
                        fail_count++;
                    end
                end
            end
            idle_count <= any_hs ? 0 : idle_count + 1;
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if (idle_count >= WDOG_MAX) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic add_item(logic [FIELD_W-1:0] d, bit v, bit l);
        t_item it;
        it.distance      = d;
        it.carries_value = v;
        it.last_sample   = l;
        pending_items.insert(pending_items.size(), it);
    endtask

    task automatic wait_drained();
        while (pending_items.size() != 0 || samples_if.valid) @(posedge i_clk);
        busy_wait = 1;
        while (expected_stats.size() != 0) @(posedge i_clk);
        busy_wait = 0;
    endtask

    function automatic logic [FIELD_W-1:0] rand_sample();
        case ($urandom_range(3))
            0: return FIELD_W'($urandom_range(255));
            1: return '1 - FIELD_W'($urandom_range(255));
            default: return FIELD_W'($urandom);
        endcase
    endfunction

    // stimulus
    initial begin
        int len;
        samples_if.valid         = 0;
        samples_if.distance      = '0;
        samples_if.carries_value = 0;
        samples_if.last_sample   = 0;
        stats_if.ready           = 0;
        fail_count  = 0;
        stim_done   = 0;
        busy_wait   = 0;
        calm_phase  = 0;
        hold_cycles = 0;
        idle_count  = 0;
        clear_set();
        i_rst_n = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;

        // directed: empty set, single extremes, even and odd sets, bare closing
        add_item('0, 0, 1);
        add_item('1, 1, 1);
        add_item('0, 1, 1);
        add_item('1, 1, 0);
        add_item('0, 1, 0);
        add_item(24'h123456, 0, 0);
        add_item('0, 0, 1);
        add_item(24'h000005, 1, 0);
        add_item(24'h000002, 1, 0);
        add_item(24'h000009, 1, 1);
        add_item(24'h555555, 1, 0);
        add_item(24'hAAAAAA, 1, 0);
        add_item(24'h7FFFFF, 1, 0);
        add_item(24'h800000, 1, 1);
        add_item('1, 1, 0);
        add_item('1, 1, 0);
        add_item('1, 0, 1);
        wait_drained();

        // long set, with results held off so the block stalls its input
        hold_cycles = HOLD_LEN;
        for (int k = 0; k < 200; k++) add_item(rand_sample(), 1, 0);
        add_item(rand_sample(), 1, 1);
        add_item(24'h000003, 1, 1);
        add_item(24'h000007, 1, 1);
        wait_drained();

        // random sets, mostly short, with a calm stretch in the middle
        for (int s = 0; s < 45; s++) begin
            calm_phase = (s >= 20 && s < 28);
            len = ($urandom_range(19) == 0) ? $urandom_range(60) : $urandom_range(8);
            for (int k = 0; k < len; k++) begin
                if ($urandom_range(9) == 0) add_item(FIELD_W'($urandom), 0, 0);
                else add_item(rand_sample(), 1, 0);
            end
            add_item(rand_sample(), $urandom_range(1), 1);
            if (s % 10 == 0) wait_drained();
        end
        calm_phase = 0;
        wait_drained();
        stim_done = 1;
        repeat (50) @(posedge i_clk);
        if (fail_count == 0 && expected_stats.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
